/* src/tnvr_pkg.sv */
// shared types and fixed field widths for the track nearest vertex resampler
package tnvr_pkg;

  localparam int COORD_W   = 32;
  localparam int SPACING_W = 31;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      start_track;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      last_of_run;
  } sample_t;

endpackage

/* src/tnvr_point_if.sv */
// valid/ready channel carrying one track point per transfer
interface tnvr_point_if;
  import tnvr_pkg::*;

  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/tnvr_sample_if.sv */
// valid/ready channel carrying one selected vertex per transfer
interface tnvr_sample_if;
  import tnvr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/track_nearest_vertex_resampler_top.sv */
// Track nearest vertex resampler: takes one track point at a time and emits up to two
// vertices per point (the nearer vertex for each sample that falls on the new segment).
// The first point of a track only becomes the previous point. For any other point a single
// shared subtract/compare unit runs a bit-per-cycle square root of dx^2+dy^2 (COORD_BITS+1
// steps) and then two remainder divisions of the segment start and end by the spacing
// (LENGTH_BITS steps each); the divisions are skipped and nothing is emitted when the
// spacing is zero. points.ready is high only between points; the last result of a point
// waits in the output register while the next point is taken.
module track_nearest_vertex_resampler_top #(
  parameter int COORD_BITS  = 32,
  parameter int LENGTH_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  tnvr_point_if.sink                      points,
  tnvr_sample_if.source                   samples,
  input  logic                            sample_spacing_we,
  input  logic [tnvr_pkg::SPACING_W-1:0]  sample_spacing_wdata
);
  import tnvr_pkg::*;

  localparam int C          = COORD_BITS;
  localparam int L          = LENGTH_BITS;
  localparam int PROD_W     = 2 * C;
  localparam int RAD_W      = 2 * C + 2;
  localparam int ROOT_W     = C + 1;
  localparam int ROOT_ITERS = C + 1;
  localparam int DIV_W      = SPACING_W + 1;
  localparam int SUB_W      = (C + 4 > DIV_W) ? C + 4 : DIV_W;
  localparam int ITER_MAX   = (L > ROOT_ITERS) ? L : ROOT_ITERS;
  localparam int CNT_W      = $clog2(ITER_MAX);
  localparam logic [L-1:0] LEN_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SUM, S_ROOT, S_ACCUM, S_DIVS, S_DIVE, S_DECIDE, S_WAIT2
  } state_t;

  state_t state;

  logic [SPACING_W-1:0]   spacing;
  logic signed [C-1:0]    cur_x, cur_y, cur_z;
  logic signed [C-1:0]    prev_x, prev_y, prev_z;
  logic                   have_prev;
  logic signed [C-1:0]    last_out_x, last_out_y, last_out_z;
  logic                   have_last;
  logic [L-1:0]           track_len;
  logic [C-1:0]           ax, ay;
  logic [PROD_W-1:0]      prod_r;
  logic [RAD_W-1:0]       rad;
  logic [ROOT_W-1:0]      root;
  logic [SUB_W-1:0]       rem;
  logic [CNT_W-1:0]       cnt;
  logic [L-1:0]           div_q;
  logic [L-1:0]           seg_r;
  logic [SPACING_W-1:0]   rs_r, re_r, first_off;
  logic                   out_valid;
  sample_t                out_r;

  // coordinate differences
  logic signed [C:0] dx, dy;
  assign dx = {cur_x[C-1], cur_x} - {prev_x[C-1], prev_x};
  assign dy = {cur_y[C-1], cur_y} - {prev_y[C-1], prev_y};

  // shared squarer
  logic [C-1:0]      mul_op;
  logic [PROD_W-1:0] prod;
  assign mul_op = (state == S_SQX) ? ax : ay;
  assign prod   = PROD_W'(mul_op) * PROD_W'(mul_op);

  // shared subtract/compare unit for square root and remainder steps
  logic [C+3:0]       sqrt_sh;
  logic [C+2:0]       trial;
  logic [DIV_W-1:0]   div_sh;
  logic [SUB_W-1:0]   sub_a, sub_b;
  logic [SUB_W:0]     diff;
  logic               ge;
  logic [SUB_W-1:0]   step_rem;
  assign sqrt_sh = {rem[C+1:0], rad[RAD_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign div_sh  = {rem[DIV_W-2:0], div_q[L-1]};
  always_comb begin
    if (state == S_ROOT) begin
      sub_a = SUB_W'(sqrt_sh);
      sub_b = SUB_W'(trial);
    end else begin
      sub_a = SUB_W'(div_sh);
      sub_b = SUB_W'(spacing);
    end
  end
  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = !diff[SUB_W];
  assign step_rem = ge ? diff[SUB_W-1:0] : sub_a;

  // segment end with saturation
  logic [L:0]   len_sum;
  logic         len_sat;
  assign len_sum = {1'b0, track_len} + (L+1)'(root);
  assign len_sat = len_sum[L];

  // selection of vertices
  logic [L-1:0] lms;
  logic         first_ok, pick_first, pick_second;
  logic         same_prev, same_cur, cur_eq_prev, emit1, emit2, slot_free;
  logic         load_out;
  assign lms         = seg_r - L'(re_r);
  assign first_ok    = L'(first_off) <= seg_r;
  assign pick_first  = (L+1)'({first_off, 1'b0}) <= {1'b0, seg_r};
  assign pick_second = {lms, 1'b0} > {1'b0, seg_r};
  assign same_prev   = have_last && last_out_x == prev_x && last_out_y == prev_y
                       && last_out_z == prev_z;
  assign same_cur    = have_last && last_out_x == cur_x && last_out_y == cur_y
                       && last_out_z == cur_z;
  assign cur_eq_prev = cur_x == prev_x && cur_y == prev_y && cur_z == prev_z;
  assign emit1       = first_ok && pick_first && !same_prev;
  assign emit2       = first_ok && pick_second && !(emit1 ? cur_eq_prev : same_cur);
  assign slot_free   = !out_valid || samples.ready;
  assign load_out    = (state == S_DECIDE && slot_free && (emit1 || emit2))
                       || (state == S_WAIT2 && samples.ready);

  assign points.ready  = (state == S_IDLE);
  assign samples.valid = out_valid;
  assign samples.data  = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      spacing   <= '0;
      have_prev <= 1'b0;
      have_last <= 1'b0;
      track_len <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_z    <= '0;
      last_out_x <= '0;
      last_out_y <= '0;
      last_out_z <= '0;
    end else begin
      if (sample_spacing_we) begin
        spacing <= sample_spacing_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && samples.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (points.valid) begin
            cur_x <= points.data.point_x[C-1:0];
            cur_y <= points.data.point_y[C-1:0];
            cur_z <= points.data.point_z[C-1:0];
            if (points.data.start_track) begin
              track_len <= '0;
              have_last <= 1'b0;
            end
            if (points.data.start_track || !have_prev) begin
              // first point of a track only becomes the previous point
              prev_x    <= points.data.point_x[C-1:0];
              prev_y    <= points.data.point_y[C-1:0];
              prev_z    <= points.data.point_z[C-1:0];
              have_prev <= 1'b1;
            end else begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          ax    <= dx[C] ? C'(-dx) : dx[C-1:0];
          ay    <= dy[C] ? C'(-dy) : dy[C-1:0];
          state <= S_SQX;
        end
        S_SQX: begin
          prod_r <= prod;
          state  <= S_SQY;
        end
        S_SQY: begin
          prod_r <= prod;
          rad    <= RAD_W'(prod_r);
          state  <= S_SUM;
        end
        S_SUM: begin
          rad   <= rad + RAD_W'(prod_r);
          root  <= '0;
          rem   <= '0;
          cnt   <= CNT_W'(ROOT_ITERS - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          rem  <= step_rem;
          root <= {root[ROOT_W-2:0], ge};
          rad  <= rad << 2;
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          div_q     <= track_len;
          seg_r     <= len_sat ? ~track_len : L'(root);
          track_len <= len_sat ? LEN_MAX : len_sum[L-1:0];
          rem       <= '0;
          cnt       <= CNT_W'(L - 1);
          if (spacing == '0) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            prev_z <= cur_z;
            state  <= S_IDLE;
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (cnt == '0) begin
            // remainder of the segment start, then divide the segment end
            rs_r  <= step_rem[SPACING_W-1:0];
            rem   <= '0;
            div_q <= track_len;
            cnt   <= CNT_W'(L - 1);
            state <= S_DIVE;
          end else begin
            rem   <= step_rem;
            div_q <= div_q << 1;
            cnt   <= cnt - CNT_W'(1);
          end
        end
        S_DIVE: begin
          first_off <= (rs_r == '0) ? '0 : spacing - rs_r;
          rem       <= step_rem;
          div_q     <= div_q << 1;
          cnt       <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            re_r  <= step_rem[SPACING_W-1:0];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (slot_free) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            prev_z <= cur_z;
            state  <= (emit1 && emit2) ? S_WAIT2 : S_IDLE;
            if (emit1) begin
              out_r.out_x       <= COORD_W'(prev_x);
              out_r.out_y       <= COORD_W'(prev_y);
              out_r.out_z       <= COORD_W'(prev_z);
              out_r.last_of_run <= !emit2;
            end else if (emit2) begin
              out_r.out_x       <= COORD_W'(cur_x);
              out_r.out_y       <= COORD_W'(cur_y);
              out_r.out_z       <= COORD_W'(cur_z);
              out_r.last_of_run <= 1'b1;
            end
            if (emit2) begin
              last_out_x <= cur_x;
              last_out_y <= cur_y;
              last_out_z <= cur_z;
              have_last  <= 1'b1;
            end else if (emit1) begin
              last_out_x <= prev_x;
              last_out_y <= prev_y;
              last_out_z <= prev_z;
              have_last  <= 1'b1;
            end
          end
        end
        S_WAIT2: begin
          // second vertex follows once the first one is transferred
          if (samples.ready) begin
            out_r.out_x       <= COORD_W'(cur_x);
            out_r.out_y       <= COORD_W'(cur_y);
            out_r.out_z       <= COORD_W'(cur_z);
            out_r.last_of_run <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/tnvr_checker.sv */
// port-level checks for the track nearest vertex resampler, bound to the top level
module tnvr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tnvr_pkg::sample_t out_data
);
  import tnvr_pkg::*;

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // a result that is not the last of its point is followed at once by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run of results ended without last_of_run");

  // no new point is taken while a point still owes results
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("point taken before its results were delivered");

endmodule

bind track_nearest_vertex_resampler_top tnvr_checker u_tnvr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (points.ready),
  .out_valid (samples.valid),
  .out_ready (samples.ready),
  .out_data  (samples.data)
);
